// ===== rtl/kwtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwtc_pkg - keyword to code shared definitions
// Keyword table, result kinds and the match bundle shared by the lookup
// and the top level.
// ----------------------------------------------------------------------------
package kwtc_pkg;

    // word buffer depth default
    localparam int unsigned MaxWordBytes = 10;

    // word separator
    localparam logic [7:0] SpaceByte = 8'h20;

    // keyword table geometry
    localparam int unsigned KwCount  = 19;
    localparam int unsigned KwMaxLen = 10;
    localparam int unsigned KwLenW   = 4;
    localparam int unsigned CodeW    = 5;

    // result kinds
    typedef enum logic [1:0] {
        KindKnown   = 2'd0,
        KindUnknown = 2'd1,
        KindNoWord  = 2'd2
    } result_kind_t;

    // one keyword: text right-aligned, first character in the highest used byte
    typedef struct packed {
        logic [KwMaxLen*8-1:0] text;
        logic [KwLenW-1:0]     len;
        logic [CodeW-1:0]      code;
    } kw_entry_t;

    localparam kw_entry_t KwTable [KwCount] = '{
        '{"tile",       4'd4,  5'h00},
        '{"change",     4'd6,  5'h01},
        '{"hertz",      4'd5,  5'h02},
        '{"firing",     4'd6,  5'h03},
        '{"centigrade", 4'd10, 5'h04},
        '{"voltage",    4'd7,  5'h05},
        '{"zero",       4'd4,  5'h09},
        '{"one",        4'd3,  5'h0A},
        '{"two",        4'd3,  5'h0B},
        '{"three",      4'd5,  5'h0C},
        '{"four",       4'd4,  5'h0D},
        '{"five",       4'd4,  5'h0E},
        '{"six",        4'd3,  5'h0F},
        '{"seven",      4'd5,  5'h10},
        '{"eight",      4'd5,  5'h11},
        '{"nine",       4'd4,  5'h12},
        '{"decade",     4'd6,  5'h13},
        '{"hundred",    4'd7,  5'h14},
        '{"thousand",   4'd8,  5'h15}
    };

    // lookup outcome
    typedef struct packed {
        logic             hit;
        logic [CodeW-1:0] code;
    } match_t;

endpackage
`default_nettype wire

// ===== rtl/kwtc_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kwtc_match - keyword table lookup
// Compares a candidate word against every keyword in parallel and returns
// the code of the one that matches.
// ----------------------------------------------------------------------------
module kwtc_match #(
    parameter int unsigned MAX_WORD_BYTES = kwtc_pkg::MaxWordBytes,
    parameter int unsigned LEN_W          = $clog2(MAX_WORD_BYTES + 1)
) (
    input  wire logic [MAX_WORD_BYTES-1:0][7:0] word_bytes,
    input  wire logic [LEN_W-1:0]               word_len,
    input  wire logic                           word_long,
    output kwtc_pkg::match_t                    match
);

    // parallel compare against all table entries
    always_comb
    begin
        logic eq;
        int   pos;
        match = '0;
        for (int k = 0; k < kwtc_pkg::KwCount; k++)
        begin
            eq = !word_long && (word_len == LEN_W'(kwtc_pkg::KwTable[k].len));
            for (int i = 0; i < MAX_WORD_BYTES; i++)
            begin
                if (i < int'(kwtc_pkg::KwTable[k].len))
                begin
                    pos = int'(kwtc_pkg::KwTable[k].len) - 1 - i;
                    eq  = eq && (word_bytes[i] == kwtc_pkg::KwTable[k].text[pos*8 +: 8]);
                end
            end
            // at most one entry can match
            if (eq)
            begin
                match.hit  = 1'b1;
                match.code = match.code | kwtc_pkg::KwTable[k].code;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/keyword_token_to_code_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_to_code_top - keyword to code converter
// Collects space-separated words one byte at a time and emits a table code
// for each closed word, or an unknown / end-of-string marker.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  in      | in_valid, in_stall | char_byte, final_byte
//  out     | out_valid, out_stall | result_kind, word_code, end_of_string
//
//  One byte per cycle sustained while in_stall is low; a result passes from
//  its byte through the input register, then the lookup into the result register.
//  The lookup is parallel compares against the constant table.
//  rst_n clears word length, overflow flag and all valid bits; the word
//  buffer is not cleared.
//  A two-entry result buffer absorbs one output stall; in_stall rises only
//  when its second entry is occupied.
// ----------------------------------------------------------------------------
module keyword_token_to_code_top #(
    parameter int unsigned MAX_WORD_BYTES = kwtc_pkg::MaxWordBytes
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_byte,
    input  wire logic       final_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      result_kind,
    output logic [4:0]      word_code,
    output logic            end_of_string
);

    localparam int unsigned LenW = $clog2(MAX_WORD_BYTES + 1);
    localparam int unsigned IdxW = $clog2(MAX_WORD_BYTES);

    typedef struct packed {
        kwtc_pkg::result_kind_t           kind;
        logic [kwtc_pkg::CodeW-1:0]       code;
        logic                             eos;
    } result_t;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       final_reg;

    // word state
    logic [7:0]      buf_reg [MAX_WORD_BYTES];
    logic [LenW-1:0] len_reg;
    logic [LenW-1:0] len_next;
    logic            long_reg;
    logic            long_next;

    // result buffer: head and skid entry
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;

    // processing terms
    logic                               proc;
    logic                               is_space;
    logic                               append;
    logic                               overflow;
    logic                               closing;
    logic                               have_word;
    logic                               has_result;
    logic                               push;
    logic                               pop;
    logic [LenW-1:0]                    cand_len;
    logic                               cand_long;
    logic [MAX_WORD_BYTES-1:0][7:0]     cand_bytes;
    kwtc_pkg::match_t                   match;
    result_t                            res;

    assign in_stall = in_valid_reg && skid_valid_reg;
    assign proc     = in_valid_reg && !skid_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg  <= char_byte;
            final_reg <= final_byte;
        end
    end

    // candidate word with the current byte appended
    always_comb
    begin
        is_space  = (byte_reg == kwtc_pkg::SpaceByte);
        append    = !is_space && (len_reg < LenW'(MAX_WORD_BYTES));
        overflow  = !is_space && !append;
        cand_len  = len_reg + {{(LenW-1){1'b0}}, append};
        cand_long = long_reg || overflow;
        for (int i = 0; i < MAX_WORD_BYTES; i++)
        begin
            if (append && (len_reg == LenW'(i)))
            begin
                cand_bytes[i] = byte_reg;
            end
            else
            begin
                cand_bytes[i] = buf_reg[i];
            end
        end
    end

    kwtc_match #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .LEN_W          (LenW)
    ) u_match (
        .word_bytes (cand_bytes),
        .word_len   (cand_len),
        .word_long  (cand_long),
        .match      (match)
    );

    // result formation
    always_comb
    begin
        closing    = is_space || final_reg;
        have_word  = (cand_len != '0) || cand_long;
        has_result = closing && (have_word || final_reg);
        if (!have_word)
        begin
            res.kind = kwtc_pkg::KindNoWord;
            res.code = '0;
            res.eos  = 1'b1;
        end
        else if (match.hit)
        begin
            res.kind = kwtc_pkg::KindKnown;
            res.code = match.code;
            res.eos  = final_reg;
        end
        else
        begin
            res.kind = kwtc_pkg::KindUnknown;
            res.code = '0;
            res.eos  = final_reg;
        end
    end

    // word state next values
    always_comb
    begin
        len_next  = len_reg;
        long_next = long_reg;
        if (proc)
        begin
            if (closing)
            begin
                len_next  = '0;
                long_next = 1'b0;
            end
            else
            begin
                len_next  = cand_len;
                long_next = cand_long;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            long_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            long_reg <= long_next;
        end
    end

    // word buffer write
    always_ff @(posedge clk)
    begin
        if (proc && append)
        begin
            buf_reg[len_reg[IdxW-1:0]] <= byte_reg;
        end
    end

    // result buffer control
    always_comb
    begin
        push            = proc && has_result;
        pop             = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next      = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign result_kind   = head_reg.kind;
    assign word_code     = head_reg.code;
    assign end_of_string = head_reg.eos;

    // checks
    a_skid_needs_head: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid entry occupied with empty head");

    a_len_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        len_reg <= LenW'(MAX_WORD_BYTES)
    ) else $error("word length beyond buffer depth");

    a_long_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        long_reg |-> (len_reg == LenW'(MAX_WORD_BYTES))
    ) else $error("overflow flag set with buffer not full");

    a_close_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && closing) |=> (len_reg == '0) && !long_reg
    ) else $error("word state not cleared after close");

endmodule
`default_nettype wire

// ===== tb/kwtc_code_checker.sv =====
// ----------------------------------------------------------------------------
// kwtc_code_checker - result checker for the keyword to code converter
// Watches both channels. Every byte transfer feeds a local model of the
// word collector and keyword lookup, which queues the expected codes. Every
// result transfer is compared field by field with the oldest queued code.
// ----------------------------------------------------------------------------
module kwtc_code_checker #(
    parameter int unsigned MAX_WORD_BYTES = kwtc_pkg::MaxWordBytes
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        final_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [4:0]  word_code,
    input  logic        end_of_string,
    output int unsigned mismatch_count,
    output int unsigned pending_codes
);

    typedef struct packed {
        kwtc_pkg::result_kind_t kind;
        logic [4:0]             code;
        logic                   eos;
    } word_result_t;

    // keyword spelling and code, same order
    string keyword_text [19] = '{
        "tile", "change", "hertz", "firing", "centigrade", "voltage",
        "zero", "one", "two", "three", "four", "five", "six", "seven",
        "eight", "nine", "decade", "hundred", "thousand"
    };
    logic [4:0] keyword_code [19] = '{
        5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h09, 5'h0A, 5'h0B,
        5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15
    };

    // model of the word collector
    logic [7:0]   held_bytes [MAX_WORD_BYTES];
    int unsigned  held_len      = 0;
    logic         held_overflow = 1'b0;
    word_result_t expected_codes [$];

    // search the keyword table for the held word
    function automatic logic find_keyword(output logic [4:0] code);
        logic same;
        code = 5'd0;
        for (int k = 0; k < 19; k++)
        begin
            if (keyword_text[k].len() == held_len)
            begin
                same = 1'b1;
                for (int i = 0; i < held_len; i++)
                    if (held_bytes[i] != 8'(keyword_text[k][i]))
                        same = 1'b0;
                if (same)
                begin
                    code = keyword_code[k];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // advance the model by one byte, queue the code it closes
    function automatic void take_byte(input logic [7:0] b, input logic fin);
        logic         is_space;
        logic [4:0]   code;
        word_result_t r;
        is_space = (b == kwtc_pkg::SpaceByte);
        if (!is_space)
        begin
            if (held_len < MAX_WORD_BYTES)
            begin
                held_bytes[held_len] = b;
                held_len++;
            end
            else
                held_overflow = 1'b1;
        end
        if (!is_space && !fin)
            return;
        if (held_len != 0 || held_overflow)
        begin
            if (!held_overflow && find_keyword(code))
            begin
                r.kind = kwtc_pkg::KindKnown;
                r.code = code;
            end
            else
            begin
                r.kind = kwtc_pkg::KindUnknown;
                r.code = 5'd0;
            end
            r.eos = fin;
            held_len      = 0;
            held_overflow = 1'b0;
            expected_codes.push_back(r);
        end
        else if (fin)
        begin
            r.kind = kwtc_pkg::KindNoWord;
            r.code = 5'd0;
            r.eos  = 1'b1;
            expected_codes.push_back(r);
        end
    endfunction

    // compare one result transfer with the oldest expected code
    function automatic void check_result();
        word_result_t exp;
        if (expected_codes.size() == 0)
        begin
            $error("unexpected result: kind %0d, code %0d, end %0d",
                   result_kind, word_code, end_of_string);
            mismatch_count++;
            return;
        end
        exp = expected_codes.pop_front();
        if (result_kind !== exp.kind)
        begin
            $error("result_kind: expected %0d, got %0d", exp.kind, result_kind);
            mismatch_count++;
        end
        if (word_code !== exp.code)
        begin
            $error("word_code: expected %0d, got %0d", exp.code, word_code);
            mismatch_count++;
        end
        if (end_of_string !== exp.eos)
        begin
            $error("end_of_string: expected %0d, got %0d", exp.eos, end_of_string);
            mismatch_count++;
        end
    endfunction

    // monitor both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_len      = 0;
            held_overflow = 1'b0;
            expected_codes.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                take_byte(char_byte, final_byte);
        end
        pending_codes = expected_codes.size();
    end

endmodule

// ===== tb/tb_keyword_token_to_code_top.sv =====
// ----------------------------------------------------------------------------
// tb_keyword_token_to_code_top - regression bench for the keyword converter
// Drives text strings into the converter: a short directed string set, then
// random sentences of keywords, near misses, overlong words and noise, with
// random gaps and output stalls, one long output hold-off and drain pauses.
// Checking is done by the code checker placed beside the converter.
// ----------------------------------------------------------------------------
module tb_keyword_token_to_code_top;

    localparam int unsigned TotalBytes    = 750;
    localparam int unsigned PressureAt    = 300;
    localparam int unsigned HoldOffCycles = 60;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned DrainCycles   = 10;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] char_byte     = 8'h00;
    logic       final_byte    = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [1:0] result_kind;
    logic [4:0] word_code;
    logic       end_of_string;

    int unsigned mismatch_count;
    int unsigned pending_codes;

    // pacing controls shared by sender and receiver
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned bytes_sent   = 0;
    int unsigned idle_cycles  = 0;

    logic [7:0] text_bytes [$];

    string keyword_words [19] = '{
        "tile", "change", "hertz", "firing", "centigrade", "voltage",
        "zero", "one", "two", "three", "four", "five", "six", "seven",
        "eight", "nine", "decade", "hundred", "thousand"
    };

    keyword_token_to_code_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_byte    (char_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .word_code    (word_code),
        .end_of_string(end_of_string)
    );

    kwtc_code_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_byte     (char_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .word_code     (word_code),
        .end_of_string (end_of_string),
        .mismatch_count(mismatch_count),
        .pending_codes (pending_codes)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset, held low from time zero and then released
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // any byte but the separator
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == kwtc_pkg::SpaceByte);
        return b;
    endfunction

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(8'(s[i]));
    endfunction

    function automatic void append_spaces(input int unsigned n);
        repeat (n) text_bytes.push_back(kwtc_pkg::SpaceByte);
    endfunction

    // one word: keyword, near miss, random or overlong
    function automatic void append_word();
        int unsigned pick;
        string       w;
        int unsigned n;
        pick = $urandom_range(0, 99);
        w    = keyword_words[$urandom_range(0, 18)];
        if (pick < 65)
            append_text(w);
        else if (pick < 78)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    n = $urandom_range(0, w.len() - 1);
                    for (int i = 0; i < w.len(); i++)
                        text_bytes.push_back(i == n ? word_byte() : 8'(w[i]));
                end
                1: append_text(w.substr(0, w.len() - 2));
                default:
                begin
                    append_text(w);
                    text_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                end
            endcase
        end
        else if (pick < 88)
        begin
            repeat ($urandom_range(1, 10)) text_bytes.push_back(word_byte());
        end
        else
        begin
            n = $urandom_range(11, 16);
            if ($urandom_range(0, 1))
            begin
                append_text("centigrade");
                n -= 10;
            end
            repeat (n) text_bytes.push_back(word_byte());
        end
    endfunction

    // well-formed sentence of at least n_words words and min_bytes bytes
    function automatic void build_sentence(input int unsigned n_words,
                                           input int unsigned min_bytes);
        if ($urandom_range(0, 3) == 0)
            append_spaces($urandom_range(1, 3));
        for (int w = 0; w < n_words || text_bytes.size() < min_bytes; w++)
        begin
            if (w > 0)
                append_spaces($urandom_range(0, 3) == 0 ? $urandom_range(2, 3) : 1);
            append_word();
        end
        if ($urandom_range(0, 1))
            append_spaces($urandom_range(1, 2));
    endfunction

    // random string: mostly sentences, some noise and bare spaces
    function automatic void build_random_string();
        int unsigned shape;
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            repeat ($urandom_range(1, 12))
                text_bytes.push_back($urandom_range(0, 3) == 0 ? kwtc_pkg::SpaceByte
                                     : 8'($urandom_range(0, 255)));
        end
        else if (shape < 12)
            append_spaces($urandom_range(1, 4));
        else
            build_sentence($urandom_range(1, 6), 0);
    endfunction

    // one byte transfer, valid left high afterwards
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send the built string, final flag on its last byte
    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    // stop offering and wait for every queued code to come out
    task automatic drain_codes();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_codes == 0);
    endtask

    // receiver: random stalls, quiet stretches, one requested hold-off
    initial
    begin : receiver
        int unsigned n;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(posedge clk);
                out_stall    <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("keyword_token_to_code_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        bit pressure_done;
        pressure_done = 1'b0;
        wait (rst_n);
        @(posedge clk);

        // spaces with nothing pending, extreme bytes, longest keyword,
        // overlong word closed by a final word byte
        append_spaces(2);
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        append_spaces(1);
        append_text("centigrade");
        append_spaces(1);
        append_text("centigrades");
        send_text();
        // final space with no word pending
        append_spaces(1);
        send_text();
        drain_codes();

        // random strings with one back-pressure episode
        while (bytes_sent < TotalBytes)
        begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if (!pressure_done && bytes_sent >= PressureAt)
            begin
                tx_quiet     = 1'b1;
                hold_off_req = 1'b1;
                build_sentence(1, 40);
                send_text();
                drain_codes();
                pressure_done = 1'b1;
            end
            else
            begin
                build_random_string();
                send_text();
                if ($urandom_range(0, 24) == 0)
                    drain_codes();
            end
        end

        drain_codes();
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0 && pending_codes == 0)
            $display("keyword_token_to_code_top regression: pass");
        else
            $display("keyword_token_to_code_top regression: fail");
        $finish;
    end

endmodule
